// File: rtl/core/ttl_probe_result_cache_unit_macros.svh
// assertion macros for the probe result cache
`ifndef TTL_PROBE_RESULT_CACHE_UNIT_MACROS_SVH
`define TTL_PROBE_RESULT_CACHE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TPC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tpc assertion failed");
// next-cycle implication
`define TPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tpc assertion failed");
`else
`define TPC_ASSERT_NOW(label, clk, rst, ante, cons)
`define TPC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: rtl/core/tpc_pkg.sv
// shared types and constants of the probe result cache
package tpc_pkg;

   // default sizes
   localparam int ENTRIES_DEF   = 8;
   localparam int KEY_BITS_DEF  = 64;
   localparam int TIME_BITS_DEF = 32;

   // fixed field widths
   localparam int FUNC_W     = 3;
   localparam int ADDR_KEY_W = 64;
   localparam int PORT_W     = 16;
   localparam int TTL_W      = 16;
   localparam int LIVE_W     = 4;
   localparam int CNT_W      = 64;

   localparam logic [TTL_W-1:0]  TTL_RESET = 16'd1000;
   localparam logic [LIVE_W-1:0] LIVE_MAX  = 4'd15;

   // function codes
   localparam logic [FUNC_W-1:0] FUNC_PROBE     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_INVAL_ALL = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_INVAL_KEY = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_TICK      = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_COUNT     = 3'd4;

   // per-beat commands to every cell
   typedef struct packed {
      logic scan;       // probe lookup with caching on
      logic clear_all;
      logic clear_key;
      logic count;
   } ctl_type;

   // data rippling from cell to cell
   typedef struct packed {
      logic              hit;        // a live match sits in an earlier cell
      logic              hit_status; // status of that match
      logic              free_seen;  // an earlier cell is free or expired
      logic [LIVE_W-1:0] live_cnt;   // saturating count of live cells so far
   } chain_type;

endpackage

// File: rtl/core/ttl_probe_result_cache_unit.sv
// top level of the fully associative probe result cache with entry lifetime
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_ready   func, address_key, address_present,
//                                            endpoint_port, has_rdma
//  rsp      out        rsp_valid/rsp_ready   status, from_cache, live_entries,
//                                            hit_total, miss_total
//  csr      in         csr_valid/csr_ready   ttl_ticks
//
// each item has an accept beat that registers it and an execute cycle that runs
// it through the cell row in one pass and loads the result register.
// one item is in flight at a time; the row of cells is the limit.
// a full result register stalls the execute cycle until the rsp beat goes.
// the next item is taken while a result still waits to be taken.
// reset clears valid bits, tick counter, hit and miss counters, ttl to 1000.
`include "ttl_probe_result_cache_unit_macros.svh"

module ttl_probe_result_cache_unit #(
   parameter int ENTRIES   = tpc_pkg::ENTRIES_DEF,
   parameter int KEY_BITS  = tpc_pkg::KEY_BITS_DEF,
   parameter int TIME_BITS = tpc_pkg::TIME_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [tpc_pkg::FUNC_W-1:0]     req_func,
   input  logic [tpc_pkg::ADDR_KEY_W-1:0] req_address_key,
   input  logic                           req_address_present,
   input  logic [tpc_pkg::PORT_W-1:0]     req_endpoint_port,
   input  logic                           req_has_rdma,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_status,
   output logic                           rsp_from_cache,
   output logic [tpc_pkg::LIVE_W-1:0]     rsp_live_entries,
   output logic [tpc_pkg::CNT_W-1:0]      rsp_hit_total,
   output logic [tpc_pkg::CNT_W-1:0]      rsp_miss_total,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tpc_pkg::TTL_W-1:0]      csr_ttl_ticks
);

   localparam int SUM_BITS = (TIME_BITS > tpc_pkg::TTL_W) ? TIME_BITS : tpc_pkg::TTL_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // registered item
   logic [tpc_pkg::FUNC_W-1:0] func_ff;
   logic [KEY_BITS-1:0]        key_ff;
   logic                       present_ff;
   logic [tpc_pkg::PORT_W-1:0] port_ff;
   logic                       rdma_ff;

   logic [tpc_pkg::TTL_W-1:0] ttl_ff;
   logic [TIME_BITS-1:0]      now_ff, now_in;
   logic [tpc_pkg::CNT_W-1:0] hits_ff, hits_in;
   logic [tpc_pkg::CNT_W-1:0] misses_ff, misses_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        status_ff, status_in;
   logic                        from_cache_ff, from_cache_in;
   logic [tpc_pkg::LIVE_W-1:0]  live_ff, live_in;

   logic                 req_beat;
   logic                 fire;
   logic                 is_probe;
   logic                 is_tick;
   logic                 is_count;
   logic                 caching_on;
   logic                 store_go;
   logic                 hit_go;
   logic                 miss_go;
   logic [SUM_BITS-1:0]  expiry_sum;
   logic [TIME_BITS-1:0] expiry_new;
   tpc_pkg::ctl_type     ctl;
   tpc_pkg::chain_type   chain [0:ENTRIES];

   assign req_ready = (state_ff == ST_IDLE);
   assign req_beat  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // execute once the result register is free or draining
   assign fire       = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign caching_on = (ttl_ff != '0);

   // function decode
   always_comb begin
      ctl      = '0;
      is_probe = 1'b0;
      is_tick  = 1'b0;
      is_count = 1'b0;
      unique case (func_ff)
         tpc_pkg::FUNC_PROBE: begin
            is_probe = 1'b1;
            ctl.scan = fire && caching_on;
         end
         tpc_pkg::FUNC_INVAL_ALL: begin
            ctl.clear_all = fire;
         end
         tpc_pkg::FUNC_INVAL_KEY: begin
            ctl.clear_key = fire;
         end
         tpc_pkg::FUNC_TICK: begin
            is_tick = 1'b1;
         end
         tpc_pkg::FUNC_COUNT: begin
            is_count  = 1'b1;
            ctl.count = fire;
         end
         default: begin
         end
      endcase
   end

   // new expiry time, wrapped to the tick width
   assign expiry_sum = SUM_BITS'(now_ff) + SUM_BITS'(ttl_ff);
   assign expiry_new = expiry_sum[TIME_BITS-1:0];

   assign hit_go   = ctl.scan && chain[ENTRIES].hit;
   assign miss_go  = ctl.scan && !chain[ENTRIES].hit;
   assign store_go = miss_go && present_ff;

   // row of entry cells
   assign chain[0] = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic fallback;
      if (i == 0) begin : g_first
         assign fallback = store_go && !chain[ENTRIES].free_seen;
      end else begin : g_rest
         assign fallback = 1'b0;
      end

      tpc_cell #(
         .KEY_BITS  (KEY_BITS),
         .TIME_BITS (TIME_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .key        (key_ff),
         .port       (port_ff),
         .present    (present_ff),
         .now        (now_ff),
         .expiry_new (expiry_new),
         .status_new (!rdma_ff),
         .store_go   (store_go),
         .fallback   (fallback),
         .chain_in   (chain[i]),
         .chain_out  (chain[i+1])
      );
   end

   // next state of control, counters and result
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      now_in        = now_ff;
      hits_in       = hits_ff;
      misses_in     = misses_ff;
      status_in     = status_ff;
      from_cache_in = from_cache_ff;
      live_in       = live_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (fire) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               status_in     = is_probe && (hit_go ? chain[ENTRIES].hit_status : !rdma_ff);
               from_cache_in = hit_go;
               live_in       = is_count ? chain[ENTRIES].live_cnt : '0;
               if (hit_go) begin
                  hits_in = hits_ff + 1'b1;
               end
               if (miss_go) begin
                  misses_in = misses_ff + 1'b1;
               end
               if (is_tick) begin
                  now_in = now_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         now_ff       <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         ttl_ff       <= tpc_pkg::TTL_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         now_ff       <= now_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         if (csr_valid && csr_ready) begin
            ttl_ff <= csr_ttl_ticks;
         end
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (req_beat) begin
         func_ff    <= req_func;
         key_ff     <= req_address_key[KEY_BITS-1:0];
         present_ff <= req_address_present;
         port_ff    <= req_endpoint_port;
         rdma_ff    <= req_has_rdma;
      end
      status_ff     <= status_in;
      from_cache_ff <= from_cache_in;
      live_ff       <= live_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_from_cache   = from_cache_ff;
   assign rsp_live_entries = live_ff;
   assign rsp_hit_total    = hits_ff;
   assign rsp_miss_total   = misses_ff;

   // checks
   `TPC_ASSERT_NEXT(a_fire_gives_rsp, clock, reset, fire, rsp_valid_ff)
   `TPC_ASSERT_NEXT(a_hit_counts, clock, reset, hit_go, hits_ff == $past(hits_ff) + 1'b1)
   `TPC_ASSERT_NOW(a_hit_or_miss, clock, reset, hits_ff != $past(hits_ff), misses_ff == $past(misses_ff))
   `TPC_ASSERT_NOW(a_no_store_on_hit, clock, reset, hit_go, !store_go)

endmodule

// File: rtl/core/tpc_cell.sv
// one cache entry cell with match, expiry and chain logic
module tpc_cell #(
   parameter int KEY_BITS  = tpc_pkg::KEY_BITS_DEF,
   parameter int TIME_BITS = tpc_pkg::TIME_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tpc_pkg::ctl_type          ctl,
   input  logic [KEY_BITS-1:0]       key,
   input  logic [tpc_pkg::PORT_W-1:0] port,
   input  logic                      present,
   input  logic [TIME_BITS-1:0]      now,
   input  logic [TIME_BITS-1:0]      expiry_new,
   input  logic                      status_new,
   input  logic                      store_go,
   input  logic                      fallback,
   input  tpc_pkg::chain_type        chain_in,
   output tpc_pkg::chain_type        chain_out
);

   logic                       valid_ff, valid_in;
   logic [KEY_BITS-1:0]        key_ff;
   logic [tpc_pkg::PORT_W-1:0] port_ff;
   logic                       status_ff;
   logic [TIME_BITS-1:0]       expiry_ff;

   logic [TIME_BITS-1:0] diff;
   logic                 expired;
   logic                 live;
   logic                 key_eq;
   logic                 wr;

   // wrap-safe expiry test: now - expiry taken as signed, above zero
   assign diff    = now - expiry_ff;
   assign expired = (diff != '0) && !diff[TIME_BITS-1];
   assign live    = valid_ff && !expired;
   assign key_eq  = present && (key_ff == key) && (port_ff == port);

   // store into the first free or expired cell, or into cell 0 as fallback
   assign wr = (store_go && !live && !chain_in.free_seen) || fallback;

   // chain outputs
   always_comb begin
      chain_out.hit        = chain_in.hit || (ctl.scan && live && key_eq);
      chain_out.hit_status = chain_in.hit ? chain_in.hit_status : status_ff;
      chain_out.free_seen  = chain_in.free_seen || !live;
      if (live && (chain_in.live_cnt != tpc_pkg::LIVE_MAX)) begin
         chain_out.live_cnt = chain_in.live_cnt + 1'b1;
      end else begin
         chain_out.live_cnt = chain_in.live_cnt;
      end
   end

   // valid bit update
   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear_all) begin
         valid_in = 1'b0;
      end
      if (ctl.clear_key && valid_ff && key_eq) begin
         valid_in = 1'b0;
      end
      // scans drop expired cells up to the hit; counts drop every expired cell
      if (((ctl.scan && !chain_in.hit) || ctl.count) && valid_ff && expired) begin
         valid_in = 1'b0;
      end
      if (wr) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // entry payload
   always_ff @(posedge clock) begin
      if (wr) begin
         key_ff    <= key;
         port_ff   <= port;
         status_ff <= status_new;
         expiry_ff <= expiry_new;
      end
   end

endmodule
